[src/btpc_pkg.sv]
// Package: types and constants for the barometric compensation core.
package btpc_pkg;

  localparam logic [31:0] BiasFine    = 32'd64000;
  localparam logic [31:0] PressOffset = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] OneQ15      = 32'd32768;
  localparam logic [31:0] RoundTemp   = 32'd128;

  // register indexes
  localparam logic [1:0] RegTempCoeffs = 2'd0;
  localparam logic [1:0] RegPressLow   = 2'd1;
  localparam logic [1:0] RegPressHigh  = 2'd2;
  localparam logic [1:0] RegPressNine  = 2'd3;
  localparam int unsigned CfgIdxW = 8;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pascal;
    logic               pressure_valid;
  } out_word_t;

  // 32-bit arithmetic shift right
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

[src/btpc_div.sv]
// Pipelined unsigned 32/32 divider, one quotient bit per stage.
module btpc_div #(
  parameter int unsigned Width = 32,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [Width-1:0] quo_o,
  output logic [SideW-1:0] side_o
);
  // entry s holds the state after stage s
  logic [Width-1:0] num_q [Width];
  logic [Width-1:0] den_q [Width];
  logic [Width-1:0] rem_q [Width];
  logic [SideW-1:0] side_q [Width];
  logic             vld_q [Width];

  for (genvar s = 0; s < Width; s++) begin : g_st
    logic [Width-1:0] num_in, den_in, rem_in;
    logic [SideW-1:0] side_in;
    logic             vld_in;
    logic [Width:0]   trial;
    logic [Width-1:0] rem_d, num_d;

    // stage input: module ports for the first stage, previous stage otherwise
    if (s == 0) begin : g_head
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign rem_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_link
      assign num_in  = num_q[s-1];
      assign den_in  = den_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // restoring step
    always_comb begin
      trial = {rem_in, num_in[Width-1]};
      num_d = {num_in[Width-2:0], 1'b0};
      rem_d = trial[Width-1:0];
      if (trial >= {1'b0, den_in}) begin
        rem_d    = Width'(trial - {1'b0, den_in});
        num_d[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        num_q[s]  <= num_d;
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Width-1];
  assign quo_o   = num_q[Width-1];
  assign side_o  = side_q[Width-1];
endmodule

[src/baro_temp_pressure_compensation_core.sv]
// Top level: barometric temperature/pressure compensation pipeline.
// Usage:
//   Input channel (in_valid_i/in_stall_o/in_word_i) takes one raw
//   pressure/temperature pair per word. Output channel (out_valid_o/
//   out_stall_i/out_word_o) returns temperature in 0.01 degC and pressure
//   in Pa with a valid flag (cleared when the pressure divisor is zero).
//   Calibration words are written through cfg_valid_i/cfg_ready_o with
//   cfg_index_i 0..3; other indexes are ignored. Write only while idle.
// Throughput: one word per cycle while the output is not stalled. Pipeline:
//   8 front stages, 32 stages of the bit-per-stage divider and 3 back
//   stages, plus the output register, lie between acceptance and out_valid_o.
// Stall: the whole pipeline advances only when the output register is
//   free or being emptied; in_stall_o mirrors that, so nothing is lost.
// Reset: clears all valid bits and the calibration registers to zero.
module baro_temp_pressure_compensation_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  btpc_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output btpc_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [btpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);
  localparam int unsigned SideW = 2;
  localparam int unsigned CfgIdxW = btpc_pkg::CfgIdxW;

  logic [47:0] tc_q;
  logic [63:0] pl_q, ph_q;
  logic [15:0] p9_q;

  assign cfg_ready_o = 1'b1;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0; pl_q <= '0; ph_q <= '0; p9_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxW'(btpc_pkg::RegTempCoeffs)) tc_q <= cfg_data_i[47:0];
      if (cfg_index_i == CfgIdxW'(btpc_pkg::RegPressLow))   pl_q <= cfg_data_i;
      if (cfg_index_i == CfgIdxW'(btpc_pkg::RegPressHigh))  ph_q <= cfg_data_i;
      if (cfg_index_i == CfgIdxW'(btpc_pkg::RegPressNine))  p9_q <= cfg_data_i[15:0];
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tc_q[15:0]};
  assign t2 = btpc_pkg::sx16(tc_q[31:16]);
  assign t3 = btpc_pkg::sx16(tc_q[47:32]);
  assign p1 = {16'd0, pl_q[15:0]};
  assign p2 = btpc_pkg::sx16(pl_q[31:16]);
  assign p3 = btpc_pkg::sx16(pl_q[47:32]);
  assign p4 = btpc_pkg::sx16(pl_q[63:48]);
  assign p5 = btpc_pkg::sx16(ph_q[15:0]);
  assign p6 = btpc_pkg::sx16(ph_q[31:16]);
  assign p7 = btpc_pkg::sx16(ph_q[47:32]);
  assign p8 = btpc_pkg::sx16(ph_q[63:48]);
  assign p9 = btpc_pkg::sx16(p9_q);

  // global advance: output register free or draining
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // front pipeline valid bits
  logic [8:1] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[7:1], in_valid_i};
    end
  end

  // stage 1: differences
  logic [31:0] s1_x_q, s1_d_q, s1_ap_q;
  logic [31:0] s1_x_d, s1_d_d;
  assign s1_x_d = {15'd0, in_word_i.raw_temperature[19:3]} - (t1 << 1);
  assign s1_d_d = {16'd0, in_word_i.raw_temperature[19:4]} - t1;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q <= s1_x_d; s1_d_q <= s1_d_d;
      s1_ap_q <= {12'd0, in_word_i.raw_pressure};
    end
  end

  // stage 2: products
  logic [31:0] s2_a_q, s2_dd_q, s2_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q  <= btpc_pkg::asr(s1_x_q * t2, 11);
      s2_dd_q <= btpc_pkg::asr(s1_d_q * s1_d_q, 12);
      s2_ap_q <= s1_ap_q;
    end
  end

  // stage 3: fine temperature
  logic [31:0] s3_fine_q, s3_ap_q, s3_b;
  assign s3_b = btpc_pkg::asr(s2_dd_q * t3, 14);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_fine_q <= s2_a_q + s3_b;
      s3_ap_q   <= s2_ap_q;
    end
  end

  // stage 4: temperature and pressure offsets
  logic [31:0] s4_temp_q, s4_a_q, s4_q_q, s4_ap_q, s4_a;
  assign s4_a = btpc_pkg::asr(s3_fine_q, 1) - btpc_pkg::BiasFine;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_temp_q <= btpc_pkg::asr(s3_fine_q * 32'd5 + btpc_pkg::RoundTemp, 8);
      s4_a_q    <= s4_a;
      s4_q_q    <= btpc_pkg::asr(s4_a, 2);
      s4_ap_q   <= s3_ap_q;
    end
  end

  // stage 5: square and linear products
  logic [31:0] s5_temp_q, s5_a_q, s5_sq_q, s5_ap5_q, s5_ap2_q, s5_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_temp_q <= s4_temp_q;
      s5_a_q    <= s4_a_q;
      s5_sq_q   <= s4_q_q * s4_q_q;
      s5_ap5_q  <= (s4_a_q * p5) << 1;
      s5_ap2_q  <= btpc_pkg::asr(p2 * s4_a_q, 1);
      s5_ap_q   <= s4_ap_q;
    end
  end

  // stage 6: second-order products
  logic [31:0] s6_temp_q, s6_b_q, s6_c_q, s6_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_temp_q <= s5_temp_q;
      s6_b_q    <= btpc_pkg::asr(s5_sq_q, 11) * p6 + s5_ap5_q;
      s6_c_q    <= btpc_pkg::asr(btpc_pkg::asr(p3 * btpc_pkg::asr(s5_sq_q, 13), 3)
                   + s5_ap2_q, 18);
      s6_ap_q   <= s5_ap_q;
    end
  end

  // stage 7: divisor and offset
  logic [31:0] s7_temp_q, s7_d_q, s7_b_q, s7_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_temp_q <= s6_temp_q;
      s7_d_q    <= btpc_pkg::asr((btpc_pkg::OneQ15 + s6_c_q) * p1, 15);
      s7_b_q    <= btpc_pkg::asr(s6_b_q, 2) + (p4 << 16);
      s7_ap_q   <= s6_ap_q;
    end
  end

  // stage 8: scaled dividend
  logic [31:0] s8_temp_q, s8_d_q, s8_p_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_temp_q <= s7_temp_q;
      s8_d_q    <= s7_d_q;
      s8_p_q    <= ((btpc_pkg::PressOffset - s7_ap_q) - btpc_pkg::asr(s7_b_q, 12))
                   * btpc_pkg::PressScale;
    end
  end

  // divider with branch: shift before or after
  logic        big;
  logic [31:0] num, quo;
  logic [SideW-1:0] side_o;
  logic        dv;
  assign big = s8_p_q[31];
  assign num = big ? s8_p_q : (s8_p_q << 1);

  // temperature rides along in the delay line; flags in side band
  logic [31:0] tdly_q [32];
  logic        zero_d;
  assign zero_d = (s8_d_q == '0);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdly_q[0] <= s8_temp_q;
      for (int i = 1; i < 32; i++) tdly_q[i] <= tdly_q[i-1];
    end
  end

  btpc_div #(.Width(32), .SideW(SideW)) u_div (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (v_q[8]),
    .num_i   (num),
    .den_i   (zero_d ? 32'd1 : s8_d_q),
    .side_i  ({big, zero_d}),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (side_o)
  );

  // back stage 1: final quotient
  logic [31:0] b1_p_q, b1_t_q;
  logic        b1_z_q, b1_v_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_p_q <= side_o[1] ? (quo << 1) : quo;
      b1_z_q <= side_o[0];
      b1_t_q <= tdly_q[31];
    end
  end

  // back stage 2: correction products
  logic [31:0] b2_p_q, b2_t_q, b2_sq_q, b2_b_q, b2_p3;
  logic        b2_z_q, b2_v_q;
  assign b2_p3 = b1_p_q >> 3;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b2_p_q  <= b1_p_q;
      b2_t_q  <= b1_t_q;
      b2_z_q  <= b1_z_q;
      b2_sq_q <= (b2_p3 * b2_p3) >> 13;
      b2_b_q  <= btpc_pkg::asr((b1_p_q >> 2) * p8, 13);
    end
  end

  // back stage 3: p9 term
  logic [31:0] b3_p_q, b3_t_q, b3_a_q, b3_b_q;
  logic        b3_z_q, b3_v_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b3_p_q <= b2_p_q; b3_t_q <= b2_t_q; b3_z_q <= b2_z_q; b3_b_q <= b2_b_q;
      b3_a_q <= btpc_pkg::asr(p9 * b2_sq_q, 12);
    end
  end

  // back valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0; b2_v_q <= 1'b0; b3_v_q <= 1'b0; out_valid_o <= 1'b0;
    end else if (adv) begin
      b1_v_q <= dv; b2_v_q <= b1_v_q; b3_v_q <= b2_v_q; out_valid_o <= b3_v_q;
    end
  end

  logic [31:0] pfin;
  assign pfin = b3_p_q + btpc_pkg::asr(b3_a_q + b3_b_q + p7, 4);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_o.temperature_centi <= b3_t_q;
      out_word_o.pressure_pascal   <= b3_z_q ? 32'd0 : pfin;
      out_word_o.pressure_valid    <= !b3_z_q;
    end
  end
endmodule

[src/btpc_checker.sv]
// Port-level checker for the compensation core, bound to the top level.
module btpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input btpc_pkg::out_word_t out_word_o
);
  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result changed under stall");

  // input stalls only when output is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

  // invalid pressure reads as zero
  a_zero_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.pressure_valid |-> out_word_o.pressure_pascal == 32'd0)
    else $error("invalid pressure not zero");
endmodule

bind baro_temp_pressure_compensation_core btpc_checker u_btpc_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_word_o
);

[test/testbench.sv]
// Testbench for the barometric temperature/pressure compensation core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency = 44;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned CfgIdxW = btpc_pkg::CfgIdxW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  btpc_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  btpc_pkg::out_word_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  baro_temp_pressure_compensation_core u_top (.*);

  always #4 clk_i = ~clk_i;

  // calibration copy used for prediction
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_plow = '0;
  logic [63:0] cal_phigh = '0;
  logic [15:0] cal_p9 = '0;

  btpc_pkg::in_word_t pending_words[$];
  btpc_pkg::out_word_t expected_words[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] shr_s(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // compensated temperature and pressure for one raw pair
  function automatic btpc_pkg::out_word_t compensate(btpc_pkg::in_word_t w);
    logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, q, sq, p;
    btpc_pkg::out_word_t r;
    adc_p = {12'd0, w.raw_pressure};
    adc_t = {12'd0, w.raw_temperature};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sext(cal_temp[31:16]);
    t3 = sext(cal_temp[47:32]);
    p1 = {16'd0, cal_plow[15:0]};
    p2 = sext(cal_plow[31:16]);
    p3 = sext(cal_plow[47:32]);
    p4 = sext(cal_plow[63:48]);
    p5 = sext(cal_phigh[15:0]);
    p6 = sext(cal_phigh[31:16]);
    p7 = sext(cal_phigh[47:32]);
    p8 = sext(cal_phigh[63:48]);
    p9 = sext(cal_p9);
    a = shr_s(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = shr_s(shr_s(d * d, 12) * t3, 14);
    fine = a + b;
    r.temperature_centi = shr_s(fine * 32'd5 + 32'd128, 8);
    a = shr_s(fine, 1) - 32'd64000;
    q = shr_s(a, 2);
    sq = q * q;
    b = shr_s(sq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = shr_s(b, 2) + (p4 << 16);
    a = shr_s(shr_s(p3 * shr_s(sq, 13), 3) + shr_s(p2 * a, 1), 18);
    d = shr_s((32'd32768 + a) * p1, 15);
    if (d == 0) begin
      r.pressure_pascal = '0;
      r.pressure_valid = 1'b0;
      return r;
    end
    p = ((32'd1048576 - adc_p) - shr_s(b, 12)) * 32'd3125;
    // large dividend: divide first, then double
    if (p < 32'h8000_0000) p = (p << 1) / d;
    else p = (p / d) << 1;
    a = shr_s(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
    b = shr_s((p >> 2) * p8, 13);
    r.pressure_pascal = p + shr_s(a + b + p7, 4);
    r.pressure_valid = 1'b1;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // write one calibration register while idle
  task automatic write_cal(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      btpc_pkg::RegTempCoeffs: cal_temp = val[47:0];
      btpc_pkg::RegPressLow: cal_plow = val;
      btpc_pkg::RegPressHigh: cal_phigh = val;
      default: cal_p9 = val[15:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // out-of-range index must be ignored
  task automatic write_bad_index();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'($urandom_range(4, 255));
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic btpc_pkg::in_word_t rand_word();
    btpc_pkg::in_word_t w;
    w.raw_pressure = 20'($urandom);
    w.raw_temperature = 20'($urandom);
    return w;
  endfunction

  int unsigned in_gap = 0;
  bit in_taken;
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  // input driver: changes at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          in_gap <= gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // expectation is formed at acceptance with the calibration in force
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) expected_words.push_back(compensate(in_word_i));
  end

  // output stall pattern
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left <= gap_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    btpc_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", out_word_o.pressure_pascal, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_word_o.temperature_centi !== want.temperature_centi)
          report_mismatch("temperature_centi", out_word_o.temperature_centi,
                          want.temperature_centi);
        if (out_word_o.pressure_pascal !== want.pressure_pascal)
          report_mismatch("pressure_pascal", out_word_o.pressure_pascal,
                          want.pressure_pascal);
        if (out_word_o.pressure_valid !== want.pressure_valid)
          report_mismatch("pressure_valid", {31'd0, out_word_o.pressure_valid},
                          {31'd0, want.pressure_valid});
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || stim_done)
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // typical calibration of a real part
  task automatic set_typical();
    write_cal(btpc_pkg::RegTempCoeffs, {16'd0, 16'hFFE8, 16'h6810, 16'h6B70});
    write_cal(btpc_pkg::RegPressLow, {16'h0B5A, 16'hD6D0, 16'hD624, 16'h8E1A});
    write_cal(btpc_pkg::RegPressHigh, {16'h2710, 16'hFF9C, 16'h006D, 16'hFFF9});
    write_cal(btpc_pkg::RegPressNine, 64'h0000_0000_0000_1770);
  endtask

  task automatic set_random();
    write_cal(btpc_pkg::RegTempCoeffs, {16'd0, 16'($urandom), 16'($urandom),
                                        16'($urandom_range(20000, 65535))});
    write_cal(btpc_pkg::RegPressLow,
              {$urandom, 16'($urandom), 16'($urandom_range(1, 65535))});
    write_cal(btpc_pkg::RegPressHigh, {$urandom, $urandom});
    write_cal(btpc_pkg::RegPressNine, {48'd0, 16'($urandom)});
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) pending_words.push_back(rand_word());
  endtask

  initial begin
    btpc_pkg::in_word_t w;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: divisor zero, pressure invalid
    w.raw_pressure = 20'hFFFFF;
    w.raw_temperature = 20'hFFFFF;
    pending_words.push_back(w);
    pending_words.push_back('0);
    wait_drained();

    // typical part with extreme and typical readings
    set_typical();
    write_bad_index();
    pending_words.push_back('0);
    pending_words.push_back({20'hFFFFF, 20'hFFFFF});
    pending_words.push_back({20'hFFFFF, 20'h00000});
    pending_words.push_back({20'h00000, 20'hFFFFF});
    pending_words.push_back({20'h655A0, 20'h7EED0});
    pending_words.push_back({20'h80000, 20'h80000});
    pending_words.push_back({20'h55555, 20'hAAAAA});
    pending_words.push_back({20'hAAAAA, 20'h55555});
    wait_drained();

    // extremes: all ones, then max positive, then most negative coefficients
    write_cal(btpc_pkg::RegTempCoeffs, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(btpc_pkg::RegPressLow, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(btpc_pkg::RegPressHigh, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(btpc_pkg::RegPressNine, 64'h0000_0000_0000_FFFF);
    pending_words.push_back('0);
    pending_words.push_back({20'hFFFFF, 20'hFFFFF});
    pending_words.push_back({20'h12345, 20'h6789A});
    wait_drained();
    write_cal(btpc_pkg::RegTempCoeffs, 64'h0000_7FFF_7FFF_FFFF);
    write_cal(btpc_pkg::RegPressLow, 64'h7FFF_7FFF_7FFF_FFFF);
    write_cal(btpc_pkg::RegPressHigh, 64'h7FFF_7FFF_7FFF_7FFF);
    write_cal(btpc_pkg::RegPressNine, 64'h0000_0000_0000_7FFF);
    push_random(4);
    wait_drained();
    write_cal(btpc_pkg::RegTempCoeffs, 64'h0000_8000_8000_0000);
    write_cal(btpc_pkg::RegPressLow, 64'h8000_8000_8000_0001);
    write_cal(btpc_pkg::RegPressHigh, 64'h8000_8000_8000_8000);
    write_cal(btpc_pkg::RegPressNine, 64'h0000_0000_0000_8000);
    push_random(4);
    wait_drained();

    // random phases: typical and random calibration in turn
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) set_typical();
      else set_random();
      if (ph == 3) write_bad_index();
      push_random(78);
      wait_drained();
    end

    stim_done = 1'b1;
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
src/btpc_pkg.sv
src/btpc_div.sv
src/baro_temp_pressure_compensation_core.sv
src/btpc_checker.sv
test/testbench.sv
